// File: sv/assert_macros.svh
// Assertion macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ccs_pkg.sv
package ccs_pkg;

  localparam int MaxCategories = 16;
  localparam int MaxConfigs    = 64;
  localparam int ProbBits      = 16;
  localparam int CatW          = 4;
  localparam int ConfW         = 6;
  localparam int AddrW         = ConfW + CatW;
  localparam int SumW          = 20;

  localparam logic [0:0] CmdLoad = 1'b0;
  localparam logic [0:0] CmdDraw = 1'b1;

  localparam logic [0:0] RegNumCategories = 1'b0;
  localparam logic [0:0] RegNumConfigs    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SORT_RD,
    ST_SORT_WT,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_SUM_RD,
    ST_SUM_WT,
    ST_SUM_WR,
    ST_SCAN_RD,
    ST_SCAN_WT,
    ST_SCAN_CHK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [SumW-1:0]   wdata;
    logic [CatW-1:0]   wcat;
    logic [AddrW-1:0]  raddr;
  } mem_ctl_t;

endpackage

// File: sv/ccs_store.sv
module ccs_store (
  input  logic                         clk,
  input  ccs_pkg::mem_ctl_t            ctl,
  output logic [ccs_pkg::SumW-1:0]     rd_weight,
  output logic [ccs_pkg::CatW-1:0]     rd_cat
);

  localparam int Depth = ccs_pkg::MaxConfigs * ccs_pkg::MaxCategories;

  logic [ccs_pkg::SumW-1:0] weight_mem [Depth];
  logic [ccs_pkg::CatW-1:0] order_mem  [Depth];

  // One write port and one registered read port for both arrays.
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      weight_mem[ctl.waddr] <= ctl.wdata;
      order_mem[ctl.waddr]  <= ctl.wcat;
    end
    rd_weight <= weight_mem[ctl.raddr];
    rd_cat    <= order_mem[ctl.raddr];
  end

endmodule

// File: sv/conditional_category_sampler_core.sv
// Channel | Direction | Handshake         | Payload
// in_     | input     | tvalid/tready     | tdata: command, config_index, config_missing,
//         |           |                   |   category_index, weight, weight_missing, uniform
// out_    | output    | tvalid/tready     | tdata: sample, sample_missing, warning
// cfg_    | input     | write enable only | cfg_index, cfg_data
//
// A load with an in-range category is written in its acceptance cycle, and the input stays ready for the next one.
// A draw from a prepared configuration scans each category through ST_SCAN_RD, ST_SCAN_WT
// and ST_SCAN_CHK until a match. The first draw after a load also runs an insertion
// sort and a running sum pass on the one read port.
// Reset is synchronous and active low; it clears the marks and the warning, not the memory.
// A stalled result holds in the output register, and the input waits until it is taken.
module conditional_category_sampler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] command, [6:1] config_index, [7] config_missing, [11:8] category_index,
  // [27:12] weight, [28] weight_missing, [44:29] uniform, [47:45] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] sample, [5] sample_missing, [6] warning, [7] zero
  output logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int CatW  = ccs_pkg::CatW;
  localparam int ConfW = ccs_pkg::ConfW;
  localparam int SumW  = ccs_pkg::SumW;

  ccs_pkg::state_t state_r, state_nxt;

  logic [4:0] num_cat_r;
  logic [6:0] num_conf_r;
  logic [ccs_pkg::MaxConfigs-1:0] prep_r, miss_r, prep_nxt, miss_nxt;
  logic warn_r, warn_nxt;

  // Captured draw fields.
  logic [ConfW-1:0] conf_r, conf_nxt;
  logic [15:0]      unif_r, unif_nxt;

  // Sequencer counters: i is the insertion index, k the hole position (slot index in sum and scan).
  logic [CatW-1:0]  i_r, i_nxt, k_r, k_nxt, last_r, last_nxt;
  logic [SumW-1:0]  key_r, key_nxt, acc_r, acc_nxt;
  logic [CatW-1:0]  kcat_r, kcat_nxt;

  logic [4:0] out_sample_r, out_sample_nxt;
  logic       out_miss_r, out_miss_nxt, out_warn_r, out_warn_nxt;

  ccs_pkg::mem_ctl_t ctl;
  logic [SumW-1:0] rd_weight;
  logic [CatW-1:0] rd_cat;

  ccs_store u_store (.clk(clk), .ctl(ctl), .rd_weight(rd_weight), .rd_cat(rd_cat));

  // Input field views.
  logic             f_cmd, f_cmiss, f_wmiss;
  logic [ConfW-1:0] f_conf;
  logic [CatW-1:0]  f_cat;
  logic [15:0]      f_weight, f_unif;
  assign f_cmd    = in_tdata[0];
  assign f_conf   = in_tdata[6:1];
  assign f_cmiss  = in_tdata[7];
  assign f_cat    = in_tdata[11:8];
  assign f_weight = in_tdata[27:12];
  assign f_wmiss  = in_tdata[28];
  assign f_unif   = in_tdata[44:29];

  // Effective category count minus one.
  logic [CatW-1:0] n_last;
  always_comb begin
    if (num_cat_r == 5'd0) begin
      n_last = '0;
    end else if (num_cat_r > 5'(ccs_pkg::MaxCategories)) begin
      n_last = CatW'(ccs_pkg::MaxCategories - 1);
    end else begin
      n_last = CatW'(num_cat_r - 5'd1);
    end
  end

  assign in_tready  = (state_r == ccs_pkg::ST_IDLE);
  assign out_tvalid = (state_r == ccs_pkg::ST_OUT);
  assign out_tdata  = {1'b0, out_warn_r, out_miss_r, out_sample_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ccs_pkg::ST_IDLE;
      num_cat_r  <= 5'd2;
      num_conf_r <= 7'd1;
      prep_r     <= '0;
      miss_r     <= '0;
      warn_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prep_r  <= prep_nxt;
      miss_r  <= miss_nxt;
      warn_r  <= warn_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ccs_pkg::RegNumCategories: num_cat_r  <= cfg_data[4:0];
          ccs_pkg::RegNumConfigs:    num_conf_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    conf_r       <= conf_nxt;
    unif_r       <= unif_nxt;
    i_r          <= i_nxt;
    k_r          <= k_nxt;
    last_r       <= last_nxt;
    key_r        <= key_nxt;
    kcat_r       <= kcat_nxt;
    acc_r        <= acc_nxt;
    out_sample_r <= out_sample_nxt;
    out_miss_r   <= out_miss_nxt;
    out_warn_r   <= out_warn_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    prep_nxt       = prep_r;
    miss_nxt       = miss_r;
    warn_nxt       = warn_r;
    conf_nxt       = conf_r;
    unif_nxt       = unif_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    last_nxt       = last_r;
    key_nxt        = key_r;
    kcat_nxt       = kcat_r;
    acc_nxt        = acc_r;
    out_sample_nxt = out_sample_r;
    out_miss_nxt   = out_miss_r;
    out_warn_nxt   = out_warn_r;
    ctl            = '0;
    ctl.raddr      = {conf_r, k_r};
    ctl.waddr      = {conf_r, k_r};

    unique case (state_r)
      ccs_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          conf_nxt = f_conf;
          unif_nxt = f_unif;
          if (f_cmd == ccs_pkg::CmdLoad) begin
            if (f_cat <= n_last) begin
              if (prep_r[f_conf]) begin
                miss_nxt[f_conf] = 1'b0;
              end
              if (f_wmiss) begin
                miss_nxt[f_conf] = 1'b1;
              end
              prep_nxt[f_conf] = 1'b0;
              ctl.we    = 1'b1;
              ctl.waddr = {f_conf, f_cat};
              ctl.wdata = f_wmiss ? '0 : SumW'(f_weight);
              ctl.wcat  = f_cat;
            end
          end else if (f_cmiss || ({1'b0, f_conf} >= num_conf_r)) begin
            warn_nxt       = 1'b1;
            out_sample_nxt = '0;
            out_miss_nxt   = 1'b1;
            out_warn_nxt   = 1'b1;
            state_nxt      = ccs_pkg::ST_OUT;
          end else if (miss_r[f_conf]) begin
            prep_nxt[f_conf] = 1'b1;
            warn_nxt       = 1'b1;
            out_sample_nxt = '0;
            out_miss_nxt   = 1'b1;
            out_warn_nxt   = 1'b1;
            state_nxt      = ccs_pkg::ST_OUT;
          end else begin
            last_nxt = n_last;
            k_nxt    = '0;
            if (prep_r[f_conf]) begin
              state_nxt = ccs_pkg::ST_SCAN_RD;
            end else begin
              prep_nxt[f_conf] = 1'b1;
              state_nxt = ccs_pkg::ST_INIT;
            end
          end
        end
      end

      // Start the sort at insertion index 0; the identity order is tagged in ST_SORT_WT.
      ccs_pkg::ST_INIT: begin
        state_nxt = ccs_pkg::ST_SORT_RD;
        if (k_r == '0) begin
          i_nxt = '0;
        end
        ctl.raddr = {conf_r, k_r};
      end

      // Read slot i as the insertion key (ST_SORT_WT also tags its order).
      ccs_pkg::ST_SORT_RD: begin
        ctl.raddr = {conf_r, i_r};
        state_nxt = ccs_pkg::ST_SORT_WT;
      end

      ccs_pkg::ST_SORT_WT: begin
        // Insert step i: the key is the raw weight of category i.
        key_nxt  = rd_weight;
        kcat_nxt = i_r;
        // Tag slot i with its category so later reads carry the order.
        ctl.we    = 1'b1;
        ctl.waddr = {conf_r, i_r};
        ctl.wdata = rd_weight;
        ctl.wcat  = i_r;
        k_nxt     = i_r;
        if (i_r == '0) begin
          if (i_r == last_r) begin
            k_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = ccs_pkg::ST_SUM_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ccs_pkg::ST_SORT_RD;
          end
        end else begin
          state_nxt = ccs_pkg::ST_SORT_CMP;
        end
      end

      // Read slot k-1 and compare with the key; shift down if smaller.
      ccs_pkg::ST_SORT_CMP: begin
        ctl.raddr = {conf_r, k_r - 1'b1};
        state_nxt = ccs_pkg::ST_SORT_PUT;
      end

      ccs_pkg::ST_SORT_PUT: begin
        ctl.we = 1'b1;
        if (rd_weight < key_r) begin
          ctl.waddr = {conf_r, k_r};
          ctl.wdata = rd_weight;
          ctl.wcat  = rd_cat;
          k_nxt     = k_r - 1'b1;
          if (k_r == CatW'(1)) begin
            state_nxt = ccs_pkg::ST_SORT_PUT;
            // Hole reached slot 0: place the key there next.
          end else begin
            state_nxt = ccs_pkg::ST_SORT_CMP;
          end
          if (k_r == CatW'(1)) begin
            state_nxt = ccs_pkg::ST_SORT_WT;
            i_nxt     = i_r;
          end
        end else begin
          ctl.waddr = {conf_r, k_r};
          ctl.wdata = key_r;
          ctl.wcat  = kcat_r;
          state_nxt = ccs_pkg::ST_SORT_RD;
        end
        if (!(rd_weight < key_r) || k_r == CatW'(1)) begin
          if (rd_weight < key_r) begin
            // Place key at slot 0 in a dedicated write below.
            state_nxt = ccs_pkg::ST_SUM_WR;
            k_nxt     = '0;
          end else if (i_r == last_r) begin
            k_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = ccs_pkg::ST_SUM_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ccs_pkg::ST_SORT_RD;
          end
        end
      end

      // Key insertion at slot 0 during the sort.
      ccs_pkg::ST_SUM_WR: begin
        ctl.we    = 1'b1;
        ctl.waddr = {conf_r, CatW'(0)};
        ctl.wdata = key_r;
        ctl.wcat  = kcat_r;
        if (i_r == last_r) begin
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ccs_pkg::ST_SUM_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ccs_pkg::ST_SORT_RD;
        end
      end

      ccs_pkg::ST_SUM_RD: begin
        ctl.raddr = {conf_r, k_r};
        state_nxt = ccs_pkg::ST_SUM_WT;
      end

      // Adder: running sum written back in place.
      ccs_pkg::ST_SUM_WT: begin
        acc_nxt   = acc_r + rd_weight;
        ctl.we    = 1'b1;
        ctl.waddr = {conf_r, k_r};
        ctl.wdata = acc_r + rd_weight;
        ctl.wcat  = rd_cat;
        if (k_r == last_r) begin
          k_nxt     = '0;
          state_nxt = ccs_pkg::ST_SCAN_RD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ccs_pkg::ST_SUM_RD;
        end
      end

      ccs_pkg::ST_SCAN_RD: begin
        ctl.raddr = {conf_r, k_r};
        state_nxt = ccs_pkg::ST_SCAN_WT;
      end

      ccs_pkg::ST_SCAN_WT: begin
        state_nxt = ccs_pkg::ST_SCAN_CHK;
        ctl.raddr = {conf_r, k_r};
      end

      // Compare: first running sum at least the uniform value wins, else the last slot.
      ccs_pkg::ST_SCAN_CHK: begin
        if ((SumW'(unif_r) <= rd_weight) || (k_r == last_r)) begin
          out_sample_nxt = {1'b0, rd_cat} + 5'd1;
          out_miss_nxt   = 1'b0;
          out_warn_nxt   = warn_r;
          state_nxt      = ccs_pkg::ST_OUT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ccs_pkg::ST_SCAN_RD;
        end
      end

      ccs_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = ccs_pkg::ST_IDLE;
        end
      end

      default: state_nxt = ccs_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: sv/ccs_checker.sv
`include "assert_macros.svh"

module ccs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  `ASSERT_IMPL(a_busy_out, clk, rst_n, out_tvalid, !in_tready, "ready while result pending")
  `ASSERT_IMPL(a_na_zero, clk, rst_n, out_tvalid && out_tdata[5], out_tdata[6:0] == 7'h60, "bad NA")
  `ASSERT_IMPL(a_sample_rng, clk, rst_n, out_tvalid && !out_tdata[5], out_tdata[4:0] - 5'd1 < 5'd16, "bad sample")
  `ASSERT_NEXT(a_warn_sticky, clk, rst_n, out_tvalid && out_tready && out_tdata[6], !out_tvalid || out_tdata[6], "warning cleared")

endmodule

bind conditional_category_sampler_core ccs_checker u_ccs_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
